/* rtl/fvmt_pkg.sv */
// ----------------------------------------------------------------------------
// fvmt_pkg
// Types and constants shared by the flow volume minute tracker.
// ----------------------------------------------------------------------------
package fvmt_pkg;

  localparam int FLOW_W = 18;
  localparam int SUM_W  = FLOW_W + 1;
  localparam int TIME_W = 32;
  localparam int VOL_W  = 40;
  localparam int MV_W   = 46;
  localparam int CNT_W  = 7;

  // dt * (f0 + f1): 33-bit signed times 19-bit signed
  localparam int PROD_W = TIME_W + 1 + SUM_W;
  localparam int DIV_D  = 120;
  localparam int REM_W  = 7;

  // divide by 120 in 13-bit digits, one digit per cycle
  localparam int CHUNK_W   = 13;
  localparam int DIV_STEPS = PROD_W / CHUNK_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int DIG_W     = CHUNK_W + REM_W;

  // floor(v / 120) = (v * ceil(2^27 / 120)) >> 27 for v < 120 * 2^13
  localparam int RECIP_SH = 27;
  localparam int RECIP_W  = 21;
  localparam int MPROD_W  = DIG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'((2**RECIP_SH + DIV_D - 1) / DIV_D);
  localparam logic [DIG_W-1:0]   DIV_DIG = DIG_W'(DIV_D);

  // Bias that makes the dividend non-negative; 120 * 2^44 is zero mod 2^40,
  // so the low quotient bits add straight into the volume.
  localparam logic [PROD_W-1:0] DIV_BIAS = PROD_W'(DIV_D) << 44;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  localparam logic [TIME_W-1:0] WINDOW_RST = TIME_W'(60000);

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_BREATH = 1'b1;

  typedef enum logic [1:0] {
    T_IDLE,
    T_INTEG,
    T_RING,
    T_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    I_IDLE,
    I_MUL,
    I_BIAS,
    I_DIV,
    I_ACC,
    I_DONE
  } integ_state_t;

  typedef enum logic [1:0] {
    R_IDLE,
    R_SCAN,
    R_LAST,
    R_DONE
  } ring_state_t;

endpackage

/* rtl/flow_volume_minute_tracker.sv */
// ----------------------------------------------------------------------------
// flow_volume_minute_tracker
// Trapezoidal flow integrator with a ring of breath slots and minute volume.
// ----------------------------------------------------------------------------
// One item at a time; every item gives one result. How long a flow sample
// takes is set by the divide of the 52-bit dt*(f0+f1) product by 120, done
// as four 13-bit digits, one per cycle. How long a breath mark takes is set
// by the scan of the slot memory through its single read port, one slot per
// cycle. Results sit in an output register; a result still waiting there
// holds the next one in the core and with it the input.
// ----------------------------------------------------------------------------
module flow_volume_minute_tracker #(
  parameter int SLOTS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fvmt_pkg::TIME_W-1:0]        cfg_window_ms,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_op,
  input  logic signed [fvmt_pkg::FLOW_W-1:0] in_flow,
  input  logic [fvmt_pkg::TIME_W-1:0]        in_time_ms,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [fvmt_pkg::VOL_W-1:0]  out_volume,
  output logic signed [fvmt_pkg::MV_W-1:0]   out_minute_volume,
  output logic [fvmt_pkg::CNT_W-1:0]         out_breath_count
);

  import fvmt_pkg::*;

  top_state_t state_r, state_nxt;

  logic [TIME_W-1:0] window_r;
  logic              op_r;
  logic              out_valid_r;
  logic [VOL_W-1:0]  out_volume_r;
  logic [MV_W-1:0]   out_mv_r;
  logic [CNT_W-1:0]  out_cnt_r;

  logic              integ_start;
  logic              integ_done;
  logic              ring_start;
  logic              ring_done;
  logic [VOL_W-1:0]  volume;
  logic [TIME_W-1:0] prev_time;
  logic [MV_W-1:0]   ring_mv;
  logic [CNT_W-1:0]  ring_cnt;
  logic              in_xfer;
  logic              out_load;

  fvmt_integ u_integ (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (integ_start),
    .flow        (in_flow),
    .time_ms     (in_time_ms),
    .done        (integ_done),
    .volume_r    (volume),
    .prev_time_r (prev_time)
  );

  fvmt_ring #(
    .SLOTS (SLOTS)
  ) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ring_start),
    .volume    (volume),
    .prev_time (prev_time),
    .window_ms (window_r),
    .done      (ring_done),
    .mv_r      (ring_mv),
    .count_r   (ring_cnt)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE: begin
        if (in_valid) state_nxt = (in_op == OP_BREATH) ? T_RING : T_INTEG;
      end
      T_INTEG: if (integ_done) state_nxt = T_OUT;
      T_RING:  if (ring_done) state_nxt = T_OUT;
      T_OUT:   if (!out_valid_r || out_ready) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state_r == T_IDLE);
    cfg_ready   = 1'b1;
    in_xfer     = in_valid && in_ready;
    integ_start = in_xfer && (in_op == OP_SAMPLE);
    ring_start  = in_xfer && (in_op == OP_BREATH);
    out_load    = (state_r == T_OUT) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      window_r    <= WINDOW_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        window_r <= cfg_window_ms;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r <= in_op;
    end
    if (out_load) begin
      out_volume_r <= volume;
      out_mv_r     <= (op_r == OP_BREATH) ? ring_mv : '0;
      out_cnt_r    <= (op_r == OP_BREATH) ? ring_cnt : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_volume        = out_volume_r;
  assign out_minute_volume = out_mv_r;
  assign out_breath_count  = out_cnt_r;

endmodule

/* rtl/fvmt_ram.sv */
// ----------------------------------------------------------------------------
// fvmt_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module fvmt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 72
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

/* rtl/fvmt_integ.sv */
// ----------------------------------------------------------------------------
// fvmt_integ
// Trapezoidal integrator: multiply, bias, floor divide by 120 in 13-bit
// digits by reciprocal multiply, accumulate into the 40-bit volume.
// ----------------------------------------------------------------------------
module fvmt_integ (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [fvmt_pkg::FLOW_W-1:0] flow,
  input  logic [fvmt_pkg::TIME_W-1:0] time_ms,
  output logic                       done,
  output logic [fvmt_pkg::VOL_W-1:0]  volume_r,
  output logic [fvmt_pkg::TIME_W-1:0] prev_time_r
);

  import fvmt_pkg::*;

  integ_state_t state_r, state_nxt;

  logic signed [FLOW_W-1:0] prev_flow_r;
  logic [TIME_W-1:0]        dt_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0]        dvd_r;
  logic [REM_W-1:0]         rem_r;
  logic [VOL_W-1:0]         quo_r;
  logic [STEP_W-1:0]        step_r;

  logic [DIG_W-1:0]         digit;
  logic [MPROD_W-1:0]       recip_prod;
  logic [CHUNK_W-1:0]       qdig;
  logic [DIG_W-1:0]         rem_full;

  assign digit      = {rem_r, dvd_r[PROD_W-1 -: CHUNK_W]};
  assign recip_prod = MPROD_W'(digit) * MPROD_W'(RECIP_M);
  assign qdig       = CHUNK_W'(recip_prod >> RECIP_SH);
  assign rem_full   = digit - DIG_W'(qdig) * DIV_DIG;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      I_IDLE: if (start) state_nxt = I_MUL;
      I_MUL:  state_nxt = I_BIAS;
      I_BIAS: state_nxt = I_DIV;
      I_DIV:  if (step_r == LAST_STEP) state_nxt = I_ACC;
      I_ACC:  state_nxt = I_DONE;
      I_DONE: state_nxt = I_IDLE;
      default: state_nxt = I_IDLE;
    endcase
  end

  always_comb begin
    done = (state_r == I_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= I_IDLE;
      prev_flow_r <= '0;
      prev_time_r <= '0;
      volume_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == I_IDLE && start) begin
        prev_flow_r <= flow;
        prev_time_r <= time_ms;
      end
      if (state_r == I_ACC) begin
        volume_r <= volume_r + quo_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == I_IDLE && start) begin
      dt_r  <= time_ms - prev_time_r;
      sum_r <= SUM_W'(prev_flow_r) + SUM_W'(flow);
    end
    if (state_r == I_MUL) begin
      prod_r <= PROD_W'($signed({1'b0, dt_r})) * PROD_W'(sum_r);
    end
    if (state_r == I_BIAS) begin
      dvd_r  <= prod_r + DIV_BIAS;
      rem_r  <= '0;
      step_r <= '0;
    end
    if (state_r == I_DIV) begin
      dvd_r  <= {dvd_r[PROD_W-CHUNK_W-1:0], CHUNK_W'(0)};
      rem_r  <= REM_W'(rem_full);
      quo_r  <= {quo_r[VOL_W-CHUNK_W-1:0], qdig};
      step_r <= step_r + 1'b1;
    end
  end

endmodule

/* rtl/fvmt_ring.sv */
// ----------------------------------------------------------------------------
// fvmt_ring
// Breath ring: records volume and time into the slot memory, then scans
// every slot and sums the written ones inside the window.
// ----------------------------------------------------------------------------
module fvmt_ring #(
  parameter int SLOTS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fvmt_pkg::VOL_W-1:0]  volume,
  input  logic [fvmt_pkg::TIME_W-1:0] prev_time,
  input  logic [fvmt_pkg::TIME_W-1:0] window_ms,
  output logic                        done,
  output logic [fvmt_pkg::MV_W-1:0]   mv_r,
  output logic [fvmt_pkg::CNT_W-1:0]  count_r
);

  import fvmt_pkg::*;

  localparam int ADDR_W = $clog2(SLOTS);
  localparam int WORD_W = VOL_W + TIME_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SLOTS - 1);

  ring_state_t state_r, state_nxt;

  logic [SLOTS-1:0]  valid_r;
  logic [ADDR_W-1:0] wslot_r;
  logic [ADDR_W-1:0] addr_r;
  logic              pend_r;
  logic              vbit_r;
  logic [WORD_W-1:0] rdata_r;
  logic              we;

  logic [VOL_W-1:0]  rd_vol;
  logic [TIME_W-1:0] rd_time;
  logic [TIME_W-1:0] age;
  logic              hit;

  fvmt_ram #(
    .DEPTH (SLOTS),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (wslot_r),
    .wdata   ({volume, prev_time}),
    .raddr   (addr_r),
    .rdata_r (rdata_r)
  );

  assign rd_vol  = rdata_r[WORD_W-1:TIME_W];
  assign rd_time = rdata_r[TIME_W-1:0];
  assign age     = prev_time - rd_time;
  assign hit     = pend_r && vbit_r && (age <= window_ms);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      R_IDLE: if (start) state_nxt = R_SCAN;
      R_SCAN: if (addr_r == LAST_ADDR) state_nxt = R_LAST;
      R_LAST: state_nxt = R_DONE;
      R_DONE: state_nxt = R_IDLE;
      default: state_nxt = R_IDLE;
    endcase
  end

  always_comb begin
    we   = (state_r == R_IDLE) && start;
    done = (state_r == R_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      valid_r <= '0;
      wslot_r <= '0;
      addr_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == R_SCAN);
      if (we) begin
        valid_r[wslot_r] <= 1'b1;
        wslot_r <= (wslot_r == LAST_ADDR) ? '0 : wslot_r + 1'b1;
        addr_r  <= '0;
      end else if (state_r == R_SCAN && addr_r != LAST_ADDR) begin
        addr_r <= addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    vbit_r <= valid_r[addr_r];
    if (we) begin
      mv_r    <= '0;
      count_r <= '0;
    end else if (hit) begin
      mv_r    <= mv_r + MV_W'($signed(rd_vol));
      count_r <= count_r + 1'b1;
    end
  end

endmodule

/* rtl/fvmt_check.sv */
// ----------------------------------------------------------------------------
// fvmt_check
// Port-level checks for the flow volume minute tracker, bound to the top.
// ----------------------------------------------------------------------------
module fvmt_check #(
  parameter int SLOTS = 64
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [fvmt_pkg::VOL_W-1:0]  out_volume,
  input logic signed [fvmt_pkg::MV_W-1:0]   out_minute_volume,
  input logic [fvmt_pkg::CNT_W-1:0]         out_breath_count
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_volume)
      && $stable(out_minute_volume) && $stable(out_breath_count))
    else $error("result changed while stalled");

  // one item in flight: no back-to-back input transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (SLOTS > 127) || (32'(out_breath_count) <= 32'(SLOTS)))
    else $error("breath count above slot count");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_breath_count == '0) && (SLOTS < 128) |-> out_minute_volume == '0)
    else $error("minute volume without counted breaths");

endmodule

bind flow_volume_minute_tracker fvmt_check #(.SLOTS(SLOTS)) u_fvmt_check (.*);

/* bench/flow_volume_minute_tracker_tb.sv */
// ----------------------------------------------------------------------------
// flow_volume_minute_tracker_tb
// Self-checking bench for the flow volume minute tracker. A queue of flow
// samples and breath marks feeds a clocked driver. Each transfer is run
// through a bench-side integrator and slot ring, and the expected results
// are queued. A clocked monitor checks every result field against the oldest
// expected entry. The window register is rewritten between phases while the
// block is idle. Both handshakes idle in random bursts, with one long output
// stall and one sender pause.
// ----------------------------------------------------------------------------
module flow_volume_minute_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fvmt_pkg::*;

  localparam int SLOTS       = 64;
  localparam int CYCLE_LIMIT = 500000;
  localparam int STALL_LEN   = 400;

  typedef struct {
    logic                     op;
    logic signed [FLOW_W-1:0] flow;
    logic [TIME_W-1:0]        time_ms;
  } flow_item_t;

  typedef struct {
    logic signed [VOL_W-1:0] volume;
    logic signed [MV_W-1:0]  minute_volume;
    logic [CNT_W-1:0]        breath_count;
  } volume_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [TIME_W-1:0]        cfg_window_ms = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_op = OP_SAMPLE;
  logic signed [FLOW_W-1:0] in_flow = '0;
  logic [TIME_W-1:0]        in_time_ms = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [VOL_W-1:0]  out_volume;
  logic signed [MV_W-1:0]   out_minute_volume;
  logic [CNT_W-1:0]         out_breath_count;

  flow_volume_minute_tracker #(.SLOTS(SLOTS)) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_window_ms     (cfg_window_ms),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_flow           (in_flow),
    .in_time_ms        (in_time_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_volume        (out_volume),
    .out_minute_volume (out_minute_volume),
    .out_breath_count  (out_breath_count)
  );

  always #5 clk = ~clk;

  // bench copy of the block state
  logic signed [VOL_W-1:0]  vol_acc = '0;
  logic signed [FLOW_W-1:0] last_flow = '0;
  logic [TIME_W-1:0]        last_time = '0;
  logic [TIME_W-1:0]        window_ms_q = WINDOW_RST;
  logic signed [VOL_W-1:0]  slot_vol [SLOTS];
  logic [TIME_W-1:0]        slot_t [SLOTS];
  bit                       slot_ok [SLOTS];
  int                       wr_slot = 0;

  flow_item_t     pend_q[$];
  volume_result_t volume_results_q[$];
  int             pushed_cnt = 0;
  int             accepted_cnt = 0;
  int             err_count = 0;
  int             cyc = 0;
  bit             idle_en = 1'b1;
  bit             stall_req = 1'b0;
  logic [TIME_W-1:0] gen_time = '0;

  flow_item_t     drv_item;
  int             in_gap = 0;
  int             rdy_gap = 0;
  int             stall_left = 0;
  volume_result_t mon_exp;

  function automatic volume_result_t predict_volume(input flow_item_t it);
    volume_result_t           r;
    logic [TIME_W-1:0]        dt;
    logic [TIME_W-1:0]        age;
    logic signed [SUM_W-1:0]  fsum;
    longint                   prod;
    longint                   quo;
    int                       cnt;
    r.minute_volume = '0;
    cnt = 0;
    if (it.op == OP_SAMPLE) begin
      dt = it.time_ms - last_time;
      fsum = last_flow + it.flow;
      prod = longint'(dt) * longint'(fsum);
      // floor toward minus infinity
      if (prod >= 0) quo = prod / 120;
      else quo = -((-prod + 119) / 120);
      vol_acc = vol_acc + quo[VOL_W-1:0];
      last_flow = it.flow;
      last_time = it.time_ms;
    end else begin
      slot_vol[wr_slot] = vol_acc;
      slot_t[wr_slot] = last_time;
      slot_ok[wr_slot] = 1'b1;
      wr_slot = (wr_slot + 1) % SLOTS;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_ok[i]) begin
          age = last_time - slot_t[i];
          if (age <= window_ms_q) begin
            r.minute_volume = r.minute_volume + slot_vol[i];
            cnt++;
          end
        end
      end
    end
    r.volume = vol_acc;
    r.breath_count = cnt[CNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_count++;
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cyc);
  endtask

  // cycle limit
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        volume_results_q.push_back(predict_volume(drv_item));
        accepted_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          drv_item = pend_q.pop_front();
          in_valid <= 1'b1;
          in_op <= drv_item.op;
          in_flow <= drv_item.flow;
          in_time_ms <= drv_item.time_ms;
          if (idle_en && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output ready, with random bursts and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_req) begin
      stall_req = 1'b0;
      stall_left = STALL_LEN;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (rdy_gap > 0) begin
      rdy_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (idle_en && $urandom_range(0, 5) == 0) rdy_gap = $urandom_range(1, 10);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (volume_results_q.size() == 0) begin
        report_mismatch("result with nothing pending", longint'(out_volume), 0);
      end else begin
        mon_exp = volume_results_q.pop_front();
        if (out_volume !== mon_exp.volume)
          report_mismatch("volume", longint'(out_volume), longint'(mon_exp.volume));
        if (out_minute_volume !== mon_exp.minute_volume)
          report_mismatch("minute_volume", longint'(out_minute_volume),
                          longint'(mon_exp.minute_volume));
        if (out_breath_count !== mon_exp.breath_count)
          report_mismatch("breath_count", longint'(out_breath_count),
                          longint'(mon_exp.breath_count));
      end
    end
  end

  task automatic push_item(input logic op, input logic signed [FLOW_W-1:0] flow,
                           input logic [TIME_W-1:0] tm);
    flow_item_t it;
    it.op = op;
    it.flow = flow;
    it.time_ms = tm;
    pend_q.push_back(it);
    pushed_cnt++;
  endtask

  task automatic push_sample(input logic signed [FLOW_W-1:0] flow,
                             input logic [TIME_W-1:0] tm);
    push_item(OP_SAMPLE, flow, tm);
    gen_time = tm;
  endtask

  // breath marks carry random, unused flow and time fields
  task automatic push_breath();
    push_item(OP_BREATH, FLOW_W'($urandom()), $urandom());
  endtask

  task automatic push_random(input int n);
    int sel;
    logic signed [FLOW_W-1:0] f;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        push_breath();
      end else begin
        sel = $urandom_range(0, 19);
        if (sel < 15) gen_time = gen_time + $urandom_range(1, 2000);
        else if (sel == 17) gen_time = $urandom();
        else if (sel == 18) gen_time = gen_time - $urandom_range(1, 50);
        sel = $urandom_range(0, 9);
        if (sel < 6) f = FLOW_W'(int'($urandom_range(0, 10000)) - 5000);
        else if (sel == 6) f = '0;
        else if (sel == 7) f = 18'sh1FFFF;
        else if (sel == 8) f = -18'sh20000;
        else f = FLOW_W'($urandom());
        push_sample(f, gen_time);
      end
    end
  endtask

  task automatic wait_drained();
    while (accepted_cnt != pushed_cnt || volume_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [TIME_W-1:0] w);
    cfg_window_ms <= w;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    window_ms_q = w;
  endtask

  logic [TIME_W-1:0] win_set [6];

  initial begin
    win_set[0] = '0;
    win_set[1] = 32'd1;
    win_set[2] = 32'hFFFF_FFFF;
    win_set[3] = 32'd3000;
    win_set[4] = $urandom();
    win_set[5] = 32'd60000;
    for (int i = 0; i < SLOTS; i++) begin
      slot_vol[i] = '0;
      slot_t[i] = '0;
      slot_ok[i] = 1'b0;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, default window
    push_breath();
    push_sample(18'sh1FFFF, 32'd1000);
    push_sample(-18'sh20000, 32'd2000);
    push_breath();
    push_sample('0, 32'd2000);
    push_breath();
    push_breath();
    push_sample(-18'sh20000, 32'd5000);
    push_sample(-18'sh20000, 32'hFFFF_FF00);
    push_breath();
    push_sample(18'sh1FFFF, 32'h0000_0100);
    push_sample(18'sh1FFFF, 32'hFFFF_FFFF);
    push_breath();
    push_sample(18'sh00001, 32'hFFFF_FFFF);
    push_sample(-18'sh00001, 32'h0000_0000);
    push_sample(-18'sh00001, 32'd7);
    push_breath();
    push_sample(18'sh2AAAA, 32'hAAAA_AAAA);
    push_sample(18'sh15555, 32'h5555_5555);
    push_breath();
    push_sample(18'sh15555, 32'h5555_5555 + 32'd50000);
    push_breath();

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      repeat (4) @(posedge clk);
      write_window(win_set[ph]);
      if (ph == 5) idle_en = 1'b0;
      if (ph == 2) begin
        push_random(100);
        wait_drained();
        push_random(100);
      end else begin
        push_random(200);
      end
      if (ph == 1) stall_req = 1'b1;
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (volume_results_q.size() != 0)
      report_mismatch("results never arrived", volume_results_q.size(), 0);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/fvmt_pkg.sv
rtl/fvmt_ram.sv
rtl/fvmt_integ.sv
rtl/fvmt_ring.sv
rtl/flow_volume_minute_tracker.sv
rtl/fvmt_check.sv
bench/flow_volume_minute_tracker_tb.sv
